// ----- hdl/acpf_pkg.sv -----
// ----------------------------------------------------------------------------
// acpf_pkg
// Shared types and constants of the atom contact pair finder.
// ----------------------------------------------------------------------------
`default_nettype none

package acpf_pkg;

  localparam int unsigned CoordW   = 25;
  localparam int unsigned ResW     = 15;
  localparam int unsigned ChainW   = 8;
  localparam int unsigned RowW     = 6;
  localparam int unsigned DistW    = 49;
  localparam int unsigned SumW     = 52;
  localparam int unsigned CutoffW  = 40;
  localparam int unsigned GapW     = 10;
  localparam int unsigned KeyW     = 2 * ResW + 2 * ChainW;
  localparam int unsigned IdxW     = 8;
  localparam int unsigned ResLimit = 63;

  localparam logic [1:0] ModeLoad  = 2'd0;
  localparam logic [1:0] ModeScan  = 2'd1;
  localparam logic [1:0] ModeClear = 2'd2;

  typedef enum logic [1:0] {
    OpLoad,
    OpScan,
    OpClear
  } op_e;

  // One classified command as it travels from the front to the back.
  typedef struct packed {
    op_e                       op;
    logic signed [CoordW-1:0]  x;
    logic signed [CoordW-1:0]  y;
    logic signed [CoordW-1:0]  z;
    logic signed [ResW-1:0]    res;
    logic [ChainW-1:0]         chain;
    logic [RowW-1:0]           row;
  } cmd_t;

  // One contact result.
  typedef struct packed {
    logic [RowW-1:0]  first_atom;
    logic [RowW-1:0]  second_atom;
    logic [DistW-1:0] dist_sq;
    logic             new_pair;
    logic [IdxW-1:0]  pair_index;
    logic             pair_overflow;
    logic             last;
  } result_t;

  typedef enum logic [3:0] {
    StIdle,
    StRow,
    StJChk,
    StDiff,
    StSq,
    StSum,
    StTest,
    StSrchRd,
    StSrchCmp,
    StPut,
    StFlush
  } state_e;

endpackage

`default_nettype wire

// ----- hdl/acpf_front.sv -----
// ----------------------------------------------------------------------------
// acpf_front
// Accepts input transfers, classifies the mode and queues commands.
// ----------------------------------------------------------------------------
`default_nettype none

module acpf_front (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [1:0]          in_mode_i,
  input  wire acpf_pkg::cmd_t      in_cmd_i,
  output logic                     cmd_valid_o,
  input  wire logic                cmd_ready_i,
  output acpf_pkg::cmd_t           cmd_o
);

  acpf_pkg::cmd_t slot_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     fill_q;
  logic           push, pop, keep;
  acpf_pkg::cmd_t cls;

  // Mode 3 means nothing and is dropped here.
  always_comb begin
    cls  = in_cmd_i;
    keep = 1'b1;
    unique case (in_mode_i)
      acpf_pkg::ModeLoad:  cls.op = acpf_pkg::OpLoad;
      acpf_pkg::ModeScan:  cls.op = acpf_pkg::OpScan;
      acpf_pkg::ModeClear: cls.op = acpf_pkg::OpClear;
      default: begin
        cls.op = acpf_pkg::OpLoad;
        keep   = 1'b0;
      end
    endcase
  end

  assign in_ready_o  = (fill_q != 2'd2);
  assign cmd_valid_o = (fill_q != 2'd0);
  assign cmd_o       = slot_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o && keep;
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      fill_q <= fill_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) slot_q[wr_ptr_q] <= cls;
  end

endmodule

`default_nettype wire

// ----- hdl/acpf_back.sv -----
// ----------------------------------------------------------------------------
// acpf_back
// Executes commands: atom store, scan walk, distance test and pair table.
// ----------------------------------------------------------------------------
`default_nettype none

module acpf_back #(
  parameter int unsigned MAX_ATOMS  = 64,
  parameter int unsigned PAIR_DEPTH = 256
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cmd_valid_i,
  output logic                                      cmd_ready_o,
  input  wire acpf_pkg::cmd_t                       cmd_i,
  input  wire logic [acpf_pkg::CutoffW-1:0]         cutoff_sq_i,
  input  wire logic [acpf_pkg::GapW-1:0]            min_gap_i,
  output logic                                      res_valid_o,
  input  wire logic                                 res_ready_i,
  output acpf_pkg::result_t                         res_o
);

  localparam int unsigned AW  = $clog2(MAX_ATOMS);
  localparam int unsigned ACW = $clog2(MAX_ATOMS + 1);
  localparam int unsigned PW  = (PAIR_DEPTH > 1) ? $clog2(PAIR_DEPTH) : 1;
  localparam int unsigned PCW = $clog2(PAIR_DEPTH + 1);

  typedef struct packed {
    logic signed [acpf_pkg::CoordW-1:0] x;
    logic signed [acpf_pkg::CoordW-1:0] y;
    logic signed [acpf_pkg::CoordW-1:0] z;
    logic signed [acpf_pkg::ResW-1:0]   res;
    logic [acpf_pkg::ChainW-1:0]        chain;
  } atom_t;

  atom_t                        atom_mem [MAX_ATOMS];
  atom_t                        atom_rd_q;
  logic [AW-1:0]                atom_ra;
  logic                         atom_we;
  logic [acpf_pkg::KeyW-1:0]    pair_mem [PAIR_DEPTH];
  logic [acpf_pkg::KeyW-1:0]    pair_rd_q;
  logic                         pair_we;

  acpf_pkg::state_e             state_q, state_d;
  logic [ACW-1:0]               cnt_q, cnt_d, i_q, i_d, j_q, j_d;
  logic [PCW-1:0]               pcnt_q, pcnt_d, p_q, p_d;
  logic [5:0]                   nres_q, nres_d;
  logic                         found_q, found_d;
  atom_t                        ai_q, aj_q;
  logic signed [acpf_pkg::CoordW:0]   dx_q, dy_q, dz_q;
  logic signed [acpf_pkg::ResW:0]     gap_q;
  logic signed [acpf_pkg::SumW-1:0]   px, py, pz;
  logic [acpf_pkg::SumW-1:0]    sx_q, sy_q, sz_q, sum_q;
  logic                         pend_v_q, pend_v_d, out_v_q, out_v_d;
  acpf_pkg::result_t            pend_q, out_q, newres;
  logic                         load_pend, load_new, load_out_last;
  logic                         out_free;
  logic [acpf_pkg::KeyW-1:0]    key;

  assign key      = {ai_q.res, aj_q.res, ai_q.chain, aj_q.chain};
  assign out_free = !out_v_q || res_ready_i;
  assign res_valid_o = out_v_q;
  assign res_o       = out_q;

  // Full-width signed squares of the coordinate differences.
  assign px = dx_q * dx_q;
  assign py = dy_q * dy_q;
  assign pz = dz_q * dz_q;

  always_comb begin
    newres.first_atom    = 6'(i_q);
    newres.second_atom   = 6'(j_q);
    newres.dist_sq       = (|sum_q[acpf_pkg::SumW-1:acpf_pkg::DistW])
                           ? {acpf_pkg::DistW{1'b1}} : sum_q[acpf_pkg::DistW-1:0];
    newres.new_pair      = !found_q;
    newres.pair_index    = '0;
    newres.pair_overflow = 1'b0;
    newres.last          = 1'b0;
    if (!found_q) begin
      if (pcnt_q < PCW'(PAIR_DEPTH)) newres.pair_index = 8'(pcnt_q);
      else                           newres.pair_overflow = 1'b1;
    end
  end

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    i_d      = i_q;
    j_d      = j_q;
    pcnt_d   = pcnt_q;
    p_d      = p_q;
    nres_d   = nres_q;
    found_d  = found_q;
    pend_v_d = pend_v_q;
    out_v_d  = out_v_q && !res_ready_i;
    cmd_ready_o   = 1'b0;
    atom_ra       = j_q[AW-1:0];
    atom_we       = 1'b0;
    pair_we       = 1'b0;
    load_pend     = 1'b0;
    load_new      = 1'b0;
    load_out_last = 1'b0;
    unique case (state_q)
      acpf_pkg::StIdle: begin
        atom_ra     = AW'(cmd_i.row);
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          unique case (cmd_i.op)
            acpf_pkg::OpLoad: begin
              if (cnt_q < ACW'(MAX_ATOMS)) begin
                atom_we = 1'b1;
                cnt_d   = cnt_q + 1'b1;
              end
            end
            acpf_pkg::OpClear: begin
              cnt_d  = '0;
              pcnt_d = '0;
            end
            acpf_pkg::OpScan: begin
              if (8'(cmd_i.row) < 8'(cnt_q)) begin
                i_d     = ACW'(cmd_i.row);
                state_d = acpf_pkg::StRow;
              end
            end
            default: ;
          endcase
        end
      end
      acpf_pkg::StRow: begin
        j_d     = i_q + 1'b1;
        nres_d  = '0;
        state_d = acpf_pkg::StJChk;
      end
      acpf_pkg::StJChk: begin
        if (j_q < cnt_q && nres_q < 6'(acpf_pkg::ResLimit)) state_d = acpf_pkg::StDiff;
        else                                                  state_d = acpf_pkg::StFlush;
      end
      acpf_pkg::StDiff:  state_d = acpf_pkg::StSq;
      acpf_pkg::StSq:    state_d = acpf_pkg::StSum;
      acpf_pkg::StSum:   state_d = acpf_pkg::StTest;
      acpf_pkg::StTest: begin
        if (sum_q > acpf_pkg::SumW'(cutoff_sq_i) ||
            gap_q <= $signed((acpf_pkg::ResW + 1)'(min_gap_i))) begin
          j_d     = j_q + 1'b1;
          state_d = acpf_pkg::StJChk;
        end else begin
          p_d     = '0;
          found_d = 1'b0;
          state_d = acpf_pkg::StSrchRd;
        end
      end
      acpf_pkg::StSrchRd: begin
        if (p_q < pcnt_q) state_d = acpf_pkg::StSrchCmp;
        else              state_d = acpf_pkg::StPut;
      end
      acpf_pkg::StSrchCmp: begin
        if (pair_rd_q == key) begin
          found_d = 1'b1;
          state_d = acpf_pkg::StPut;
        end else begin
          p_d     = p_q + 1'b1;
          state_d = acpf_pkg::StSrchRd;
        end
      end
      acpf_pkg::StPut: begin
        if (!pend_v_q || out_free) begin
          if (pend_v_q) begin
            load_pend = 1'b1;
            out_v_d   = 1'b1;
          end
          load_new = 1'b1;
          pend_v_d = 1'b1;
          if (!found_q && pcnt_q < PCW'(PAIR_DEPTH)) begin
            pair_we = 1'b1;
            pcnt_d  = pcnt_q + 1'b1;
          end
          nres_d  = nres_q + 1'b1;
          j_d     = j_q + 1'b1;
          state_d = acpf_pkg::StJChk;
        end
      end
      acpf_pkg::StFlush: begin
        if (!pend_v_q) begin
          state_d = acpf_pkg::StIdle;
        end else if (out_free) begin
          load_out_last = 1'b1;
          out_v_d       = 1'b1;
          pend_v_d      = 1'b0;
          state_d       = acpf_pkg::StIdle;
        end
      end
      default: state_d = acpf_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= acpf_pkg::StIdle;
      cnt_q    <= '0;
      pcnt_q   <= '0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      pcnt_q   <= pcnt_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q     <= i_d;
    j_q     <= j_d;
    p_q     <= p_d;
    nres_q  <= nres_d;
    found_q <= found_d;
    if (state_q == acpf_pkg::StRow) ai_q <= atom_rd_q;
    if (state_q == acpf_pkg::StDiff) begin
      aj_q  <= atom_rd_q;
      dx_q  <= (acpf_pkg::CoordW + 1)'(atom_rd_q.x) - (acpf_pkg::CoordW + 1)'(ai_q.x);
      dy_q  <= (acpf_pkg::CoordW + 1)'(atom_rd_q.y) - (acpf_pkg::CoordW + 1)'(ai_q.y);
      dz_q  <= (acpf_pkg::CoordW + 1)'(atom_rd_q.z) - (acpf_pkg::CoordW + 1)'(ai_q.z);
      gap_q <= (acpf_pkg::ResW + 1)'(atom_rd_q.res) - (acpf_pkg::ResW + 1)'(ai_q.res);
    end
    if (state_q == acpf_pkg::StSq) begin
      sx_q <= $unsigned(px);
      sy_q <= $unsigned(py);
      sz_q <= $unsigned(pz);
    end
    if (state_q == acpf_pkg::StSum) sum_q <= sx_q + sy_q + sz_q;
    if (load_pend) out_q <= pend_q;
    if (load_new)  pend_q <= newres;
    // The flag of the final result is the lowest bit of the packed result.
    if (load_out_last) out_q <= {pend_q[$bits(acpf_pkg::result_t)-1:1], 1'b1};
  end

  // Atom store: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (atom_we) atom_mem[cnt_q[AW-1:0]] <= {cmd_i.x, cmd_i.y, cmd_i.z, cmd_i.res, cmd_i.chain};
    atom_rd_q <= atom_mem[atom_ra];
  end

  // Pair key table: append-only, searched one entry per read.
  always_ff @(posedge clk_i) begin
    if (pair_we) pair_mem[pcnt_q[PW-1:0]] <= key;
    pair_rd_q <= pair_mem[p_q[PW-1:0]];
  end

endmodule

`default_nettype wire

// ----- hdl/atom_contact_pair_finder_top.sv -----
// ----------------------------------------------------------------------------
// atom_contact_pair_finder_top
// Finds atom pairs in contact within a cutoff and numbers residue pairs.
// ----------------------------------------------------------------------------
// A load transfer (mode 0) stores one atom, a scan transfer (mode 1) walks all
// later atoms of the named row and emits one result transfer per contact, up to
// 63 per scan, and a clear transfer (mode 2) empties the atom store and the pair
// table. A scan takes its command, fetches the row, tests each later atom (end
// check, difference, square, sum, test), and flushes the last result at the end;
// each contact adds the key search, since the pair table has one read port and
// is read one entry at a time, and then the result is put. A two-entry command
// queue sits between input acceptance and execution, so input transfers keep
// being taken while a scan runs until the queue is full, and a result register
// lets a contact wait on the output without blocking the walk until the next
// contact is found. The last result of a scan carries tlast; a scan without
// contacts gives none.
// ----------------------------------------------------------------------------
`default_nettype none

module atom_contact_pair_finder_top #(
  parameter int unsigned MAX_ATOMS  = 64,
  parameter int unsigned PAIR_DEPTH = 256
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // Input stream.
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // coord_x[24:0], coord_y[49:25], coord_z[74:50], residue[89:75],
  // chain[97:90], row[103:98]
  input  wire logic [103:0] s_axis_tdata,
  // mode[1:0]
  input  wire logic [1:0]   s_axis_tuser,
  // Result stream.
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // first_atom[5:0], second_atom[11:6], dist_sq[60:12], new_pair[61],
  // pair_index[69:62], pair_overflow[70], zero pad[71]
  output logic [71:0]       m_axis_tdata,
  output logic              m_axis_tlast,
  // Configuration port: cutoff_sq at 0x0, min_residue_gap at 0x8.
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [3:0]   paddr,
  input  wire logic [63:0]  pwdata,
  output logic [63:0]       prdata,
  output logic              pready
);

  logic [acpf_pkg::CutoffW-1:0] cutoff_q;
  logic [acpf_pkg::GapW-1:0]    gap_q;
  acpf_pkg::cmd_t               in_cmd, cmd;
  logic                         cmd_valid, cmd_ready;
  acpf_pkg::result_t            res;

  assign pready = 1'b1;
  assign prdata = paddr[3] ? 64'(gap_q) : 64'(cutoff_q);

  // Registers are decoded on address bit 3 alone.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cutoff_q <= 40'd16000000;
      gap_q    <= 10'd3;
    end else if (psel && penable && pwrite) begin
      if (paddr[3]) gap_q    <= pwdata[acpf_pkg::GapW-1:0];
      else          cutoff_q <= pwdata[acpf_pkg::CutoffW-1:0];
    end
  end

  always_comb begin
    in_cmd.op    = acpf_pkg::OpLoad;
    in_cmd.x     = s_axis_tdata[24:0];
    in_cmd.y     = s_axis_tdata[49:25];
    in_cmd.z     = s_axis_tdata[74:50];
    in_cmd.res   = s_axis_tdata[89:75];
    in_cmd.chain = s_axis_tdata[97:90];
    in_cmd.row   = s_axis_tdata[103:98];
  end

  acpf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_mode_i   (s_axis_tuser),
    .in_cmd_i    (in_cmd),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  acpf_back #(
    .MAX_ATOMS  (MAX_ATOMS),
    .PAIR_DEPTH (PAIR_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .cutoff_sq_i (cutoff_q),
    .min_gap_i   (gap_q),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = {1'b0, res.pair_overflow, res.pair_index, res.new_pair,
                         res.dist_sq, res.second_atom, res.first_atom};
  assign m_axis_tlast = res.last;

endmodule

`default_nettype wire
